@@ rtl/core/srlm_pkg.sv @@
// shared widths, register indexes, reset values and arithmetic constants
package srlm_pkg;

  // channel field widths
  localparam int LED_TOTAL_W = 7;
  localparam int LED_NUM_W   = 6;
  localparam int DIST_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK = 3'd6;

  // register reset values
  localparam logic signed [15:0] COS_RST    = 16'sd16384;
  localparam logic signed [15:0] SIN_RST    = 16'sd0;
  localparam logic        [15:0] SCALE_RST  = 16'd4096;
  localparam logic signed [15:0] OFF_RST    = 16'sd0;
  localparam logic        [4:0]  FIRST_RST  = 5'd15;
  localparam logic        [3:0]  SHRINK_RST = 4'd2;

  // default chain length limit
  localparam int MAX_LEDS_DEF = 64;

  // coordinate normalization: divide by 45 * 2^15, round half away from zero
  localparam int  DEN_SHIFT = 15;
  localparam int  DIV_K     = 45;
  localparam longint unsigned HALF_DEN = (longint'(DIV_K) << DEN_SHIFT) / 2;
  // floor(2^32 / 45), product is shifted down by RECIP_SHIFT
  localparam int  RECIP_SHIFT = 32;
  localparam longint unsigned RECIP_45 = (64'd1 << RECIP_SHIFT) / DIV_K;

  // integer square root over a 42 bit radicand
  localparam int ROOT_W     = 42;
  localparam int ROOT_STEPS = ROOT_W / 2;

endpackage

@@ rtl/core/srlm_ifs.sv @@
// valid/ready channel interfaces for start items, results and register writes
interface srlm_cmd_if import srlm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [LED_TOTAL_W-1:0] led_total;

  modport source (output valid, output led_total, input ready);
  modport sink   (input valid, input led_total, output ready);
endinterface

interface srlm_res_if import srlm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LED_NUM_W-1:0] led_number;
  logic [DIST_W-1:0]    distance;
  logic                 last_of_run;

  modport source (output valid, output led_number, output distance, output last_of_run,
                  input ready);
  modport sink   (input valid, input led_number, input distance, input last_of_run,
                  output ready);
endinterface

interface srlm_cfg_if import srlm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/serpentine_led_radial_map_top.sv @@
// serpentine led radial map: walks the strip layout and emits one distance per led
// sequence: the start transfer is taken in idle, then each led runs through
//   12 products on the shared multiplier, each issued and then taken, 21 square root
//   steps and a load of the output register
// throughput: one start item per run; an unaccepted result stalls the next emit until
//   the result sink takes it; cmd.ready is low while a run is in flight
// reset: synchronous active high rst clears the sequencer and output valid and
//   loads every configuration register with its reset value; no clearing pass
module serpentine_led_radial_map_top import srlm_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  srlm_cmd_if.sink   cmd,
  srlm_res_if.source result,
  srlm_cfg_if.sink   cfg
);

  // run counter width: must hold the clamped total
  localparam int CNT_MIN_W = $clog2(MAX_LEDS + 1);
  localparam int TOT_W     = (CNT_MIN_W > LED_TOTAL_W) ? CNT_MIN_W : LED_TOTAL_W;

  // datapath widths, from the bounds of the layout and register ranges
  localparam int MUL_W  = 28;          // signed operand width of the shared multiplier
  localparam int PROD_W = 2 * MUL_W;
  localparam int ROT_W  = 26;          // |x*c - y*s| < 612 * 2^15
  localparam int NV_W   = 26;          // rounded magnitude after the 2^15 shift
  localparam int Q_W    = 21;          // quotient by 45
  localparam int ABS_W  = 21;          // |coordinate| in q4.12
  localparam int SV_W   = 22;          // signed coordinate in q4.12

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_TAKE  = 5'b00100,
    S_ROOT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  // micro-op sequence of one led
  typedef enum logic [3:0] {
    OP_XC   = 4'd0,
    OP_YS   = 4'd1,
    OP_XS   = 4'd2,
    OP_YC   = 4'd3,
    OP_XSC  = 4'd4,
    OP_XRC  = 4'd5,
    OP_XFIX = 4'd6,
    OP_YSC  = 4'd7,
    OP_YRC  = 4'd8,
    OP_YFIX = 4'd9,
    OP_SQX  = 4'd10,
    OP_SQY  = 4'd11
  } op_t;

  // configuration registers
  logic signed [15:0] rot_cos;
  logic signed [15:0] rot_sin;
  logic        [15:0] scale;
  logic signed [15:0] off_x;
  logic signed [15:0] off_y;
  logic        [4:0]  first_len;
  logic        [3:0]  shrink;

  // sequencer and walk state
  state_t           state;
  op_t              op;
  logic [4:0]       strip;
  logic [4:0]       pos;
  logic             dir;        // 0 forward, 1 backward
  logic [4:0]       cur_len;
  logic [TOT_W-1:0] emitted;
  logic [TOT_W-1:0] total;

  // datapath registers
  logic signed [PROD_W-1:0] prod;
  logic signed [ROT_W-1:0]  xr;
  logic signed [ROT_W-1:0]  yr;
  logic        [NV_W-1:0]   nv;
  logic                     neg;
  logic        [Q_W-1:0]    q;
  logic        [ABS_W-1:0]  ax;
  logic        [ABS_W-1:0]  ay;
  logic        [ROOT_W-1:0] sq;
  logic        [ROOT_W-1:0] root_v;
  logic        [ROOT_W-1:0] root_res;
  logic        [ROOT_W-1:0] root_bit;
  logic        [4:0]        root_cnt;

  // output register
  logic                 out_valid;
  logic [LED_NUM_W-1:0] out_num;
  logic [DIST_W-1:0]    out_dist;
  logic                 out_last;

  // ---------------------------------------------------------------------------
  // configuration port, always ready
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cos   <= COS_RST;
      rot_sin   <= SIN_RST;
      scale     <= SCALE_RST;
      off_x     <= OFF_RST;
      off_y     <= OFF_RST;
      first_len <= FIRST_RST;
      shrink    <= SHRINK_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_COS:    rot_cos   <= cfg.data;
        CFG_SIN:    rot_sin   <= cfg.data;
        CFG_SCALE:  scale     <= cfg.data;
        CFG_OFF_X:  off_x     <= cfg.data;
        CFG_OFF_Y:  off_y     <= cfg.data;
        CFG_FIRST:  first_len <= cfg.data[4:0];
        CFG_SHRINK: shrink    <= cfg.data[3:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // start handling: clamp the requested count to the chain limit
  // ---------------------------------------------------------------------------
  logic [TOT_W-1:0] req_total;
  logic [TOT_W-1:0] clamp_total;

  assign cmd.ready   = (state == S_IDLE);
  assign req_total   = TOT_W'(cmd.led_total);
  assign clamp_total = (req_total > TOT_W'(MAX_LEDS)) ? TOT_W'(MAX_LEDS) : req_total;

  // ---------------------------------------------------------------------------
  // led point in half units: x = 12*strip + 3*pos, y = 5*pos
  // ---------------------------------------------------------------------------
  logic [8:0] pt_x;
  logic [7:0] pt_y;

  assign pt_x = ({4'd0, strip} << 3) + ({4'd0, strip} << 2) + ({4'd0, pos} << 1)
              + {4'd0, pos};
  assign pt_y = ({3'd0, pos} << 2) + {3'd0, pos};

  // ---------------------------------------------------------------------------
  // shared multiplier operand select
  // ---------------------------------------------------------------------------
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_XC: begin
        mul_a = MUL_W'(signed'({1'b0, pt_x}));
        mul_b = MUL_W'(rot_cos);
      end
      OP_YS: begin
        mul_a = MUL_W'(signed'({1'b0, pt_y}));
        mul_b = MUL_W'(rot_sin);
      end
      OP_XS: begin
        mul_a = MUL_W'(signed'({1'b0, pt_x}));
        mul_b = MUL_W'(rot_sin);
      end
      OP_YC: begin
        mul_a = MUL_W'(signed'({1'b0, pt_y}));
        mul_b = MUL_W'(rot_cos);
      end
      OP_XSC: begin
        mul_a = MUL_W'(xr);
        mul_b = MUL_W'(signed'({1'b0, scale}));
      end
      OP_YSC: begin
        mul_a = MUL_W'(yr);
        mul_b = MUL_W'(signed'({1'b0, scale}));
      end
      OP_XRC, OP_YRC: begin
        mul_a = MUL_W'(signed'({1'b0, nv}));
        mul_b = MUL_W'(signed'({1'b0, RECIP_45[MUL_W-2:0]}));
      end
      OP_XFIX, OP_YFIX: begin
        mul_a = MUL_W'(signed'({1'b0, q}));
        mul_b = MUL_W'(DIV_K);
      end
      OP_SQX: begin
        mul_a = MUL_W'(signed'({1'b0, ax}));
        mul_b = MUL_W'(signed'({1'b0, ax}));
      end
      OP_SQY: begin
        mul_a = MUL_W'(signed'({1'b0, ay}));
        mul_b = MUL_W'(signed'({1'b0, ay}));
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // product post-processing
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] prod_mag;
  logic [41:0]       rounded;
  logic [NV_W:0]     rem;
  logic [Q_W-1:0]    q_fix;
  logic signed [SV_W-1:0] q_signed;
  logic signed [SV_W-1:0] coord;
  logic [ABS_W-1:0]  coord_abs;
  logic [ROOT_W-1:0] sq_sum;

  always_comb begin
    // round half away from zero: magnitude plus half the divisor, then shift by 2^15
    prod_mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    rounded   = prod_mag[41:0] + 42'(HALF_DEN);
    // reciprocal quotient is low by at most one, one correction step fixes it
    rem       = {1'b0, nv} - prod[NV_W:0];
    q_fix     = q + Q_W'(rem >= (NV_W+1)'(DIV_K));
    q_signed  = neg ? -SV_W'(signed'({1'b0, q_fix})) : SV_W'(signed'({1'b0, q_fix}));
    coord     = q_signed + SV_W'((op == OP_YFIX) ? off_y : off_x);
    coord_abs = coord[SV_W-1] ? ABS_W'(-coord) : ABS_W'(coord);
    sq_sum    = sq + prod[ROOT_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // square root step, one result bit per cycle
  // ---------------------------------------------------------------------------
  logic [ROOT_W:0]     root_trial;
  logic                root_fit;
  logic [ROOT_W-1:0]   root_res_next;
  logic [ROOT_W-1:0]   root_v_next;

  always_comb begin
    root_trial    = {1'b0, root_res} + {1'b0, root_bit};
    root_fit      = {1'b0, root_v} >= root_trial;
    root_v_next   = root_fit ? (root_v - root_trial[ROOT_W-1:0]) : root_v;
    root_res_next = root_fit ? ((root_res >> 1) + root_bit) : (root_res >> 1);
  end

  // ---------------------------------------------------------------------------
  // serpentine advance, evaluated when a result is loaded
  // ---------------------------------------------------------------------------
  logic             at_end;
  logic [4:0]       len_next;
  logic [TOT_W-1:0] cnt_next;
  logic             run_last;
  logic [DIST_W-1:0] dist_sat;
  logic             out_free;

  always_comb begin
    at_end   = dir ? (pos == 5'd0) : (({1'b0, pos} + 6'd1) >= {1'b0, cur_len});
    len_next = (cur_len > {1'b0, shrink}) ? (cur_len - {1'b0, shrink}) : 5'd0;
    cnt_next = emitted + TOT_W'(1);
    // ends on the requested count, or when the next strip would be empty
    run_last = (at_end && (len_next == 5'd0)) || (cnt_next >= total);
    dist_sat = (root_res > ROOT_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                    : root_res[DIST_W-1:0];
    out_free = !out_valid || result.ready;
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      op      <= OP_XC;
      strip   <= '0;
      pos     <= '0;
      dir     <= 1'b0;
      cur_len <= '0;
      emitted <= '0;
      total   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            strip   <= '0;
            pos     <= '0;
            dir     <= 1'b0;
            cur_len <= first_len;
            emitted <= '0;
            total   <= clamp_total;
            op      <= OP_XC;
            // empty first strip or zero count: run gives no results
            if ((clamp_total != '0) && (first_len != 5'd0)) begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          state <= S_TAKE;
        end
        S_TAKE: begin
          if (op == OP_SQY) begin
            state <= S_ROOT;
          end else begin
            op    <= op_t'(op + 4'd1);
            state <= S_ISSUE;
          end
        end
        S_ROOT: begin
          if (root_cnt == 5'd0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            emitted <= cnt_next;
            op      <= OP_XC;
            if (at_end) begin
              strip   <= strip + 5'd1;
              cur_len <= len_next;
              dir     <= !dir;
              pos     <= (len_next == 5'd0 || dir) ? 5'd0 : (len_next - 5'd1);
            end else begin
              pos <= dir ? (pos - 5'd1) : (pos + 5'd1);
            end
            state <= run_last ? S_IDLE : S_ISSUE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_ISSUE) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_TAKE) begin
      case (op)
        OP_XC:   xr <= prod[ROT_W-1:0];
        OP_YS:   xr <= xr - prod[ROT_W-1:0];
        OP_XS:   yr <= prod[ROT_W-1:0];
        OP_YC:   yr <= yr + prod[ROT_W-1:0];
        OP_XSC, OP_YSC: begin
          neg <= prod[PROD_W-1];
          nv  <= rounded[DEN_SHIFT+NV_W-1:DEN_SHIFT];
        end
        OP_XRC, OP_YRC: q <= prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
        OP_XFIX: ax <= coord_abs;
        OP_YFIX: ay <= coord_abs;
        OP_SQX:  sq <= prod[ROOT_W-1:0];
        OP_SQY: begin
          root_v   <= sq_sum;
          root_res <= '0;
          root_bit <= ROOT_W'(1) << (ROOT_W - 2);
          root_cnt <= 5'(ROOT_STEPS - 1);
        end
        default: ;
      endcase
    end
    if (state == S_ROOT) begin
      root_v   <= root_v_next;
      root_res <= root_res_next;
      root_bit <= root_bit >> 2;
      root_cnt <= root_cnt - 5'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // output register, parts the result sink from the sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_num  <= emitted[LED_NUM_W-1:0];
      out_dist <= dist_sat;
      out_last <= run_last;
    end
  end

  assign result.valid       = out_valid;
  assign result.led_number  = out_num;
  assign result.distance    = out_dist;
  assign result.last_of_run = out_last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (emitted < total))
    else $error("led count ran past the run total");

  a_strip_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> (cur_len != 5'd0))
    else $error("led computed on an empty strip");

  a_pos_in_strip: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> (pos < cur_len))
    else $error("position outside the current strip");

  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("result valid raised outside the emit step");

  a_root_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && root_cnt == 5'd0) |=> (state == S_EMIT))
    else $error("square root did not hand over to emit");

endmodule
